### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

### src/ase_sm_pkg.sv
// ----------------------------------------------------------------------------
// ase_sm_pkg
// Shared constants and types of the static-dephasing signal evaluator.
// ----------------------------------------------------------------------------
package ase_sm_pkg;

  localparam int NUM_W      = 29;   // te*4096 + t2/2
  localparam int DEN_W      = 16;
  localparam int DIV_STAGES = NUM_W;
  localparam int XP_W       = 39;   // exponent term before te/t2
  localparam int X_W        = XP_W + 1;
  localparam int XC_W       = 22;   // clamped exponent, Q.16
  localparam int TERMS      = 9;
  localparam int EXP_LAT    = 5 + 2 * TERMS;

  localparam logic signed [15:0]    TAU_CUT_RESET = 16'sd3840;
  localparam logic [14:0]           COEF_03       = 15'd19661;
  localparam logic [16:0]           INV_LN2_Q16   = 17'd94548;
  localparam logic [29:0]           LN2_Q30       = 30'd744261118;
  localparam logic signed [X_W-1:0] X_LO          = -40'sd1179648;
  localparam logic signed [X_W-1:0] X_HI          = 40'sd1114112;
  localparam logic [23:0]           SIG_MAX       = 24'hFFFFFF;

  localparam logic REG_TAU_CUT = 1'b0;

  typedef struct packed {
    logic signed [XP_W-1:0] xpart;
    logic [23:0]            s0;
    logic                   last;
  } div_side_t;

  // ceil(2^34 / i): exact floor division for dividends below 2^30
  function automatic logic [33:0] recip(input int unsigned i);
    logic [33:0] r;
    case (i)
      2: r = 34'd8589934592;
      3: r = 34'd5726623062;
      4: r = 34'd4294967296;
      5: r = 34'd3435973837;
      6: r = 34'd2863311531;
      7: r = 34'd2454267027;
      8: r = 34'd2147483648;
      9: r = 34'd1908874354;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/ase_sm_div.sv
// ----------------------------------------------------------------------------
// ase_sm_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ase_sm_div import ase_sm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  div_side_t        side_i,
  output logic             vld_o,
  output logic [NUM_W-1:0] quo_o,
  output div_side_t        side_o
);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] den;
    div_side_t        side;
  } div_st_t;

  div_st_t                st_q [DIV_STAGES];
  div_st_t                st_d [DIV_STAGES];
  logic [DIV_STAGES-1:0]  vld_q;

  always_comb begin
    div_st_t          prev;
    logic [DEN_W:0]   trial;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        prev.num  = num_i;
        prev.rem  = '0;
        prev.quo  = '0;
        prev.den  = den_i;
        prev.side = side_i;
      end else begin
        prev = st_q[k-1];
      end
      trial        = {prev.rem, prev.num[NUM_W-1]};
      st_d[k]      = prev;
      st_d[k].num  = {prev.num[NUM_W-2:0], 1'b0};
      st_d[k].quo  = {prev.quo[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, prev.den}) begin
        st_d[k].rem    = DEN_W'(trial - {1'b0, prev.den});
        st_d[k].quo[0] = 1'b1;
      end else begin
        st_d[k].rem = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign vld_o  = vld_q[DIV_STAGES-1];
  assign quo_o  = st_q[DIV_STAGES-1].quo;
  assign side_o = st_q[DIV_STAGES-1].side;

  `ASSERT_IMPLIES(div_lat_a, vld_o, $past(vld_i, DIV_STAGES), "divider valid out of step")
  `ASSERT_IMPLIES(div_rem_a, vld_o, st_q[DIV_STAGES-1].rem < st_q[DIV_STAGES-1].den, "remainder not below divisor")
  `ASSERT_IMPLIES(div_num_a, vld_o, st_q[DIV_STAGES-1].num == '0, "dividend bits left over")

endmodule

### src/ase_sm_exp.sv
// ----------------------------------------------------------------------------
// ase_sm_exp
// Pipelined s0 * exp(x): clamp, base-2 split, Taylor series, scale and round.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ase_sm_exp import ase_sm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic signed [X_W-1:0] x_i,
  input  logic [23:0]           s0_i,
  input  logic                  last_i,
  output logic                  vld_o,
  output logic [23:0]           signal_o,
  output logic                  last_o
);

  typedef struct packed {
    logic [30:0]       p;
    logic [30:0]       term;
    logic [29:0]       t;
    logic [23:0]       s0;
    logic signed [5:0] n;
    logic              last;
  } tay_t;

  // clamp
  logic                   e1_vld_q, e1_last_q;
  logic signed [XC_W-1:0] e1_xc_q;
  logic [23:0]            e1_s0_q;
  logic signed [X_W-1:0]  e1_xc_d;

  always_comb begin
    if (x_i < X_LO) begin
      e1_xc_d = X_LO;
    end else if (x_i > X_HI) begin
      e1_xc_d = X_HI;
    end else begin
      e1_xc_d = x_i;
    end
  end

  // y = x/ln2, split into integer and fraction
  logic              e2_vld_q, e2_last_q;
  logic signed [5:0] e2_n_q;
  logic [15:0]       e2_f_q;
  logic [23:0]       e2_s0_q;
  logic [20:0]       e2_mag;
  logic [37:0]       e2_prod;
  logic [20:0]       e2_ym;
  logic signed [21:0] e2_y;

  assign e2_mag  = e1_xc_q[XC_W-1] ? 21'(-e1_xc_q) : 21'(e1_xc_q);
  assign e2_prod = e2_mag * INV_LN2_Q16 + 38'd32768;
  assign e2_ym   = e2_prod[36:16];
  assign e2_y    = e1_xc_q[XC_W-1] ? -$signed({1'b0, e2_ym}) : $signed({1'b0, e2_ym});

  // t = f*ln2, Q.30
  logic [45:0] e3_prod;
  tay_t        mb_q   [TERMS+1];
  tay_t        mb_d   [TERMS+1];
  tay_t        ma_q   [TERMS];
  tay_t        ma_d   [TERMS];
  logic [TERMS:0]   mb_vld_q;
  logic [TERMS-1:0] ma_vld_q;

  assign e3_prod = e2_f_q * LN2_Q30 + 46'd32768;

  always_comb begin
    logic [60:0] mp;
    logic [64:0] dp;
    mb_d[0].p    = 31'd1 << 30;
    mb_d[0].term = 31'd1 << 30;
    mb_d[0].t    = e3_prod[45:16];
    mb_d[0].s0   = e2_s0_q;
    mb_d[0].n    = e2_n_q;
    mb_d[0].last = e2_last_q;
    for (int i = 0; i < TERMS; i++) begin
      mp           = mb_q[i].term * mb_q[i].t + 61'd536870912;
      ma_d[i]      = mb_q[i];
      ma_d[i].term = 31'(mp[60:30]) + 31'((i + 1) >> 1);
      mb_d[i+1]    = ma_q[i];
      dp           = ma_q[i].term * recip(i + 1);
      if (i == 0) begin
        mb_d[i+1].term = ma_q[i].term;
      end else begin
        mb_d[i+1].term = dp[64:34];
      end
      mb_d[i+1].p = ma_q[i].p + mb_d[i+1].term;
    end
  end

  // scale
  logic              p1_vld_q, p1_last_q;
  logic [54:0]       p1_prod_q;
  logic signed [5:0] p1_n_q;
  logic [6:0]        p2_sh;
  logic [56:0]       p2_rnd;

  assign p2_sh  = 7'(7'sd30 - 7'(p1_n_q));
  assign p2_rnd = ({2'b00, p1_prod_q} + (57'd1 << (p2_sh - 7'd1))) >> p2_sh;

  logic        vld_q, last_q;
  logic [23:0] signal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
      mb_vld_q <= '0;
      ma_vld_q <= '0;
      p1_vld_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      e1_vld_q <= vld_i;
      e2_vld_q <= e1_vld_q;
      mb_vld_q <= {ma_vld_q, e2_vld_q};
      ma_vld_q <= mb_vld_q[TERMS-1:0];
      p1_vld_q <= mb_vld_q[TERMS];
      vld_q    <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_xc_q   <= e1_xc_d[XC_W-1:0];
    e1_s0_q   <= s0_i;
    e1_last_q <= last_i;
    e2_n_q    <= e2_y[21:16];
    e2_f_q    <= e2_y[15:0];
    e2_s0_q   <= e1_s0_q;
    e2_last_q <= e1_last_q;
    mb_q      <= mb_d;
    ma_q      <= ma_d;
    p1_prod_q <= mb_q[TERMS].s0 * mb_q[TERMS].p;
    p1_n_q    <= mb_q[TERMS].n;
    p1_last_q <= mb_q[TERMS].last;
    signal_q  <= (p2_rnd > 57'(SIG_MAX)) ? SIG_MAX : p2_rnd[23:0];
    last_q    <= p1_last_q;
  end

  assign vld_o    = vld_q;
  assign signal_o = signal_q;
  assign last_o   = last_q;

  `ASSERT_IMPLIES(exp_lat_a, vld_o, $past(vld_i, EXP_LAT), "exp valid out of step")
  `ASSERT_IMPLIES(exp_n_a, e2_vld_q, (e2_n_q >= -6'sd26) && (e2_n_q <= 6'sd24), "exponent integer part out of range")
  `ASSERT_IMPLIES(exp_p_a, mb_vld_q[TERMS], mb_q[TERMS].p[30], "2^f below one")

endmodule

### src/ase_signal_model_eval.sv
// ----------------------------------------------------------------------------
// ase_signal_model_eval
// qBOLD static-dephasing signal evaluator, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One sample is accepted every clock (busy_o stays low) and each result comes
// out with done_o high for a single cycle; the receiver cannot stall it, so
// results must be taken as they come. Most of the pipeline is the te/t2
// divider, which resolves one quotient bit per stage over 29 stages; there are
// also four front stages for the exponent terms and 23 for the exponential.
// tau_cut is sampled when a sample is accepted; write it only while idle.
module ase_signal_model_eval import ase_sm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [23:0]        s0_i,
  input  logic [15:0]        lambda_frac_i,
  input  logic [15:0]        omega_i,
  input  logic [15:0]        t2_time_i,
  input  logic signed [15:0] tau_i,
  input  logic [15:0]        echo_time_i,
  input  logic               is_last_i,
  output logic               done_o,
  output logic [23:0]        signal_o,
  output logic               last_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef struct packed {
    logic [15:0] lam;
    logic [15:0] t2;
    logic [15:0] te;
    logic [23:0] s0;
    logic        last;
  } front_t;

  logic signed [15:0] tau_cut_q;

  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_cut_q <= TAU_CUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TAU_CUT)) begin
      tau_cut_q <= pwdata[15:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAU_CUT: prdata = {{16{tau_cut_q[15]}}, tau_cut_q};
      default:     prdata = '0;
    endcase
  end

  // stage 1: omega*tau, regime select
  logic               f1_vld_q, f1_short_q;
  logic signed [32:0] f1_w_q;
  front_t             f1_c_q;

  // stage 2: (omega*tau)^2 or lambda*omega*tau
  logic               f2_vld_q, f2_short_q, f2_neg_q;
  logic [33:0]        f2_v_q;
  front_t             f2_c_q;
  logic [31:0]        f2_mag;
  logic [63:0]        f2_sq;
  logic [48:0]        f2_lm;

  assign f2_mag = f1_w_q[32] ? 32'(-f1_w_q) : 32'(f1_w_q);
  assign f2_sq  = f2_mag * f2_mag + 64'd134217728;
  assign f2_lm  = f2_mag * f1_c_q.lam + 49'd524288;

  // stage 3: times lambda, or long-regime sum
  logic                   f3_vld_q, f3_short_q;
  logic signed [XP_W-1:0] f3_v_q;
  front_t                 f3_c_q;
  logic [50:0]            f3_pa;
  logic signed [XP_W-1:0] f3_lam4, f3_m, f3_xl;

  assign f3_pa   = f2_v_q * f2_c_q.lam + 51'd8192;
  assign f3_lam4 = $signed(XP_W'({f2_c_q.lam, 2'b00}));
  assign f3_m    = $signed(XP_W'(f2_v_q[27:0]));
  assign f3_xl   = f2_neg_q ? (f3_lam4 + f3_m) : (f3_lam4 - f3_m);

  // stage 4: times 0.3 and negated (short regime), or long-regime sum passed on
  logic                   f4_vld_q;
  logic signed [XP_W-1:0] f4_xp_q;
  front_t                 f4_c_q;
  logic [51:0]            f4_pb;

  assign f4_pb = f3_v_q[35:0] * COEF_03 + 52'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= start_i && !busy_o;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_w_q      <= $signed({1'b0, omega_i}) * tau_i;
    f1_short_q  <= (tau_i <= tau_cut_q);
    f1_c_q.lam  <= lambda_frac_i;
    f1_c_q.t2   <= (t2_time_i == '0) ? 16'd1 : t2_time_i;
    f1_c_q.te   <= echo_time_i;
    f1_c_q.s0   <= s0_i;
    f1_c_q.last <= is_last_i;

    f2_v_q     <= f1_short_q ? f2_sq[61:28] : {6'b0, f2_lm[47:20]};
    f2_neg_q   <= f1_w_q[32];
    f2_short_q <= f1_short_q;
    f2_c_q     <= f1_c_q;

    f3_v_q     <= f2_short_q ? $signed(XP_W'(f3_pa[49:14])) : f3_xl;
    f3_short_q <= f2_short_q;
    f3_c_q     <= f2_c_q;

    f4_xp_q <= f3_short_q ? -$signed(XP_W'(f4_pb[51:16])) : f3_v_q;
    f4_c_q  <= f3_c_q;
  end

  // te/t2 in Q.12, rounded
  logic [NUM_W-1:0]  div_num;
  div_side_t         div_side_in, div_side_out;
  logic              div_vld;
  logic [NUM_W-1:0]  div_quo;
  logic signed [X_W-1:0] x_full;

  assign div_num          = {1'b0, f4_c_q.te, 12'b0} + NUM_W'(f4_c_q.t2[15:1]);
  assign div_side_in.xpart = f4_xp_q;
  assign div_side_in.s0    = f4_c_q.s0;
  assign div_side_in.last  = f4_c_q.last;

  ase_sm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f4_vld_q),
    .num_i  (div_num),
    .den_i  (f4_c_q.t2),
    .side_i (div_side_in),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side_out)
  );

  assign x_full = $signed({div_side_out.xpart[XP_W-1], div_side_out.xpart})
                - $signed({11'b0, div_quo});

  ase_sm_exp u_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (div_vld),
    .x_i      (x_full),
    .s0_i     (div_side_out.s0),
    .last_i   (div_side_out.last),
    .vld_o    (done_o),
    .signal_o (signal_o),
    .last_o   (last_out_o)
  );

endmodule
